FILE: design/alle_pkg.sv
// Shared types and codes for the array linked list engine.
package alle_pkg;

  // Operation codes carried in the mode field
  localparam logic [1:0] MODE_AFTER = 2'd0;
  localparam logic [1:0] MODE_TAIL  = 2'd1;
  localparam logic [1:0] MODE_MATCH = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_BADPOS = 2'd2;

  // Command word
  typedef struct packed {
    logic [1:0]        mode;
    logic [9:0]        position;
    logic signed [31:0] match_value;
    logic signed [31:0] new_value;
  } alle_in_t;

  // Result word
  typedef struct packed {
    logic [1:0]        status;
    logic [9:0]        new_node;
    logic              match_found;
    logic signed [31:0] node_value;
    logic [9:0]        node_next;
  } alle_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture the command word
    logic decode;    // register the status code
    logic ptr_init;  // set the list pointer from the mode
    logic rd;        // read both node memories at the pointer
    logic step;      // advance the pointer along the link just read
    logic found;     // mark a value match
    logic wr_new;    // write the new node
    logic wr_prev;   // relink the predecessor or head, update tail and count
  } alle_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] mode;
    logic       err;
    logic       ptr_zero;
    logic       match;
  } alle_sts_t;

endpackage

FILE: design/alle_datapath.sv
// Node memories, list registers and result forming for the list engine.
module alle_datapath import alle_pkg::*; #(
  parameter int NODES = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  alle_in_t  in_i,
  input  alle_cmd_t cmd_i,
  output alle_sts_t sts_o,
  output alle_out_t res_o
);

  localparam int IW = $clog2(NODES);
  localparam int PW = (IW > 10) ? IW : 10;
  localparam logic [IW-1:0] LAST = IW'(NODES - 1);

  logic [31:0]   value_mem [NODES];
  logic [IW-1:0] link_mem  [NODES];

  alle_in_t      in_q;
  logic [1:0]    status_q;
  logic          found_q;
  logic [IW-1:0] ptr_q, head_q, tail_q, count_q;
  logic [31:0]   val_rd_q;
  logic [IW-1:0] lnk_rd_q;

  logic [PW-1:0] pos_w, count_w, next_w;
  logic [IW-1:0] pos_idx, fresh, prev_next, wr_addr, wr_link;
  logic          pos_ok, room, ptr_zero, ok;
  logic [1:0]    err_code;

  assign pos_w    = PW'(in_q.position);
  assign pos_idx  = pos_w[IW-1:0];
  assign count_w  = PW'(count_q);
  assign pos_ok   = pos_w <= count_w;
  assign room     = count_q < LAST;
  assign fresh    = count_q + 1'b1;
  assign ptr_zero = ptr_q == '0;
  // successor of the insert point; the head link lives in a register
  assign prev_next = ptr_zero ? head_q : lnk_rd_q;

  // error check: position first, then free node
  always_comb begin
    err_code = ST_OK;
    priority if ((in_q.mode == MODE_READ || in_q.mode == MODE_AFTER) && !pos_ok) begin
      err_code = ST_BADPOS;
    end else if (in_q.mode != MODE_READ && !room) begin
      err_code = ST_FULL;
    end else begin
      err_code = ST_OK;
    end
  end

  assign sts_o.mode     = in_q.mode;
  assign sts_o.err      = err_code != ST_OK;
  assign sts_o.ptr_zero = ptr_zero;
  assign sts_o.match    = val_rd_q == 32'(in_q.match_value);

  // command word and status capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q <= in_i;
    end
    if (cmd_i.decode) begin
      status_q <= err_code;
    end
  end

  // match flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.load) begin
      found_q <= 1'b0;
    end else if (cmd_i.found) begin
      found_q <= 1'b1;
    end
  end

  // list pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else if (cmd_i.ptr_init) begin
      unique case (in_q.mode)
        MODE_TAIL:  ptr_q <= tail_q;
        MODE_MATCH: ptr_q <= head_q;
        default:    ptr_q <= pos_idx;
      endcase
    end else if (cmd_i.step) begin
      ptr_q <= lnk_rd_q;
    end
  end

  // head link, tail and allocation count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.wr_prev) begin
      if (ptr_zero) begin
        head_q <= fresh;
      end
      if (ptr_q == tail_q) begin
        tail_q <= fresh;
      end
      count_q <= fresh;
    end
  end

  // registered reads of both node memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      val_rd_q <= value_mem[ptr_q];
      lnk_rd_q <= link_mem[ptr_q];
    end
  end

  // single link write port: new node first, predecessor next
  assign wr_addr = cmd_i.wr_new ? fresh : ptr_q;
  assign wr_link = cmd_i.wr_new ? prev_next : fresh;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_new) begin
      value_mem[fresh] <= 32'(in_q.new_value);
    end
    if (cmd_i.wr_new || (cmd_i.wr_prev && !ptr_zero)) begin
      link_mem[wr_addr] <= wr_link;
    end
  end

  // result word; count already holds the new node when it is shown
  assign ok     = status_q == ST_OK;
  assign next_w = PW'(prev_next);

  always_comb begin
    res_o             = '0;
    res_o.status      = status_q;
    if (ok && in_q.mode == MODE_READ) begin
      res_o.node_value = ptr_zero ? '0 : $signed(val_rd_q);
      res_o.node_next  = next_w[9:0];
    end else if (ok) begin
      res_o.new_node    = count_w[9:0];
      res_o.match_found = found_q;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= LAST) else $error("allocation count beyond last node");

  a_tail_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q <= count_q) else $error("tail points at unallocated node");

  a_write_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_new |-> room) else $error("node write without a free node");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_prev |=> count_q == $past(count_q) + 1'b1)
    else $error("count did not advance by one on insert");

endmodule

FILE: design/alle_ctrl.sv
// Sequencing state machine for the list engine.
module alle_ctrl import alle_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  output logic      done_o,
  input  alle_sts_t sts_i,
  output alle_cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_DECODE  = 7'b0000010,
    S_READ    = 7'b0000100,
    S_CMP     = 7'b0001000,
    S_WR_NEW  = 7'b0010000,
    S_WR_PREV = 7'b0100000,
    S_RESP    = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.decode = 1'b1;
        if (sts_i.err) begin
          state_d = S_RESP;
        end else begin
          cmd_o.ptr_init = 1'b1;
          state_d        = S_READ;
        end
      end
      S_READ: begin
        // end of list in a search: insert at front
        if (sts_i.mode == MODE_MATCH && sts_i.ptr_zero) begin
          state_d = S_WR_NEW;
        end else begin
          cmd_o.rd = 1'b1;
          unique case (sts_i.mode)
            MODE_READ:  state_d = S_RESP;
            MODE_MATCH: state_d = S_CMP;
            default:    state_d = S_WR_NEW;
          endcase
        end
      end
      S_CMP: begin
        if (sts_i.match) begin
          cmd_o.found = 1'b1;
          state_d     = S_WR_NEW;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = S_READ;
        end
      end
      S_WR_NEW: begin
        cmd_o.wr_new = 1'b1;
        state_d      = S_WR_PREV;
      end
      S_WR_PREV: begin
        cmd_o.wr_prev = 1'b1;
        state_d       = S_RESP;
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy   = state_q != S_IDLE;
  assign done_o = state_q == S_RESP;

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state register not one-hot");

  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> state_q == S_DECODE) else $error("word accepted but not decoded");

  a_single_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy) else $error("result strobe longer than one cycle");

endmodule

FILE: design/array_linked_list_engine.sv
// Top level of the array linked list engine: controller plus datapath.
// Accept (start && !busy) to done_o: error: decode; read: decode, read; insert: decode, read, new node
// and predecessor writes, match reading and comparing per node to the hit or list end; next word after done_o.
// Rate is set by the single registered read and single link write port of the node memories.
// The result is shown for one cycle with done_o; the receiver cannot stall it.
// Reset clears head, tail, count and control state; node memories need no clearing pass.
module array_linked_list_engine import alle_pkg::*; #(
  parameter int NODES = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  alle_in_t  in_i,
  output logic      done_o,
  output alle_out_t res_o
);

  alle_cmd_t cmd;
  alle_sts_t sts;

  // sequencer
  alle_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // node storage and result forming
  alle_datapath #(
    .NODES (NODES)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .res_o  (res_o)
  );

endmodule
